[design/sfdd_pkg.sv]
package sfdd_pkg;

    // Frame framing bytes
    localparam logic [7:0] END_MARKER   = 8'h22;
    localparam logic [7:0] HDR_STATUS   = 8'h30;
    localparam logic [7:0] HDR_CHANNEL  = 8'h73;
    localparam logic [7:0] CHECK_SEED   = 8'h55;
    localparam logic [7:0] LIMIT_RESET  = 8'd50;
    localparam logic [3:0] KEEP_RESET   = 4'hF;
    localparam logic [3:0] PEDAL_XOR    = 4'h3;
    localparam logic [7:0] DIR_MAX      = 8'h02;

    // Body layout: data bytes, then checksum byte, then terminator
    localparam int FRAME_BODY_BYTES = 10;
    localparam int DATA_BYTES       = 8;
    localparam int BODY_CNT_W       = 4;
    localparam logic [BODY_CNT_W-1:0] LAST_BODY_IDX  = BODY_CNT_W'(FRAME_BODY_BYTES - 1);
    localparam logic [BODY_CNT_W-1:0] CHECK_BODY_IDX = BODY_CNT_W'(FRAME_BODY_BYTES - 2);

    // Configuration register indexes
    localparam logic CFG_KEEP_MASK = 1'b0;
    localparam logic CFG_LIMIT     = 1'b1;

    // Result status codes
    localparam logic [1:0] FS_STATUS_OK  = 2'd0;
    localparam logic [1:0] FS_CHANNEL_OK = 2'd1;
    localparam logic [1:0] FS_CHECK_ERR  = 2'd2;
    localparam logic [1:0] FS_DIR_ERR    = 2'd3;

    localparam int VAL_W  = 17;
    localparam int TIME_W = 20;

    // One finished frame handed from parser to decoder
    typedef struct packed {
        logic                    err;
        logic                    is_chan;
        logic [8*DATA_BYTES-1:0] body;
    } t_frame_rec;

endpackage

[design/sfdd_front.sv]
module sfdd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_rx_byte,
    input  logic [7:0]          i_limit,
    output logic                o_push,
    output sfdd_pkg::t_frame_rec o_rec
);

    typedef enum logic [1:0] {
        ST_HUNT,
        ST_HEADER,
        ST_BODY
    } t_state;

    t_state                            r_state;
    logic                              r_is_chan;
    logic [sfdd_pkg::BODY_CNT_W-1:0]   r_body_cnt;
    logic [7:0]                        r_check;
    logic [7:0]                        r_hunt_cnt;
    logic [7:0]                        r_body [sfdd_pkg::DATA_BYTES];

    logic                              last_byte;
    logic                              frame_err;

    // Final body byte closes the frame
    assign last_byte = i_accept && (r_state == ST_BODY)
                       && (r_body_cnt == sfdd_pkg::LAST_BODY_IDX);
    assign frame_err = (r_check != 8'h00) || (i_rx_byte != sfdd_pkg::END_MARKER);
    assign o_push    = last_byte;

    always_comb begin
        o_rec.err     = frame_err;
        o_rec.is_chan = r_is_chan;
        for (int k = 0; k < sfdd_pkg::DATA_BYTES; k++) begin
            o_rec.body[8*k +: 8] = r_body[k];
        end
    end

    // Byte parser: hunt, header, body
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_HUNT;
            r_is_chan  <= 1'b0;
            r_body_cnt <= '0;
            r_check    <= sfdd_pkg::CHECK_SEED;
            r_hunt_cnt <= '0;
        end else if (i_accept) begin
            case (r_state)
                ST_HUNT: begin
                    if (i_rx_byte == sfdd_pkg::END_MARKER || r_hunt_cnt >= i_limit) begin
                        r_state    <= ST_HEADER;
                        r_hunt_cnt <= '0;
                    end else begin
                        r_hunt_cnt <= r_hunt_cnt + 8'd1;
                    end
                end
                ST_HEADER: begin
                    if (i_rx_byte == sfdd_pkg::HDR_STATUS
                            || i_rx_byte == sfdd_pkg::HDR_CHANNEL) begin
                        r_is_chan  <= (i_rx_byte == sfdd_pkg::HDR_CHANNEL);
                        r_state    <= ST_BODY;
                        r_body_cnt <= '0;
                        r_check    <= sfdd_pkg::CHECK_SEED;
                    end else begin
                        r_state    <= ST_HUNT;
                        r_hunt_cnt <= '0;
                    end
                end
                ST_BODY: begin
                    if (r_body_cnt < sfdd_pkg::CHECK_BODY_IDX) begin
                        r_body[r_body_cnt[2:0]] <= i_rx_byte;
                        r_check    <= r_check ^ i_rx_byte;
                        r_body_cnt <= r_body_cnt + sfdd_pkg::BODY_CNT_W'(1);
                    end else if (r_body_cnt < sfdd_pkg::LAST_BODY_IDX) begin
                        // checksum byte: running value goes to zero on match
                        r_check    <= r_check ^ i_rx_byte;
                        r_body_cnt <= r_body_cnt + sfdd_pkg::BODY_CNT_W'(1);
                    end else begin
                        r_body_cnt <= '0;
                        if (frame_err) begin
                            r_state    <= ST_HUNT;
                            r_hunt_cnt <= '0;
                        end else if (!r_is_chan && r_body[3] > sfdd_pkg::DIR_MAX) begin
                            r_state    <= ST_HUNT;
                            r_hunt_cnt <= '0;
                        end else begin
                            r_state <= ST_HEADER;
                        end
                    end
                end
                default: begin
                    r_state    <= ST_HUNT;
                    r_hunt_cnt <= '0;
                end
            endcase
        end
    end

endmodule

[design/sfdd_fifo.sv]
module sfdd_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  sfdd_pkg::t_frame_rec i_rec,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_avail,
    output sfdd_pkg::t_frame_rec o_rec
);

    // Two-entry frame queue
    sfdd_pkg::t_frame_rec r_mem [2];
    logic                 r_wr_ptr;
    logic                 r_rd_ptr;
    logic [1:0]           r_count;

    logic                 do_push;
    logic                 do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_avail = (r_count != 2'd0);
    assign o_rec   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_avail;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) r_wr_ptr <= ~r_wr_ptr;
            if (do_pop)  r_rd_ptr <= ~r_rd_ptr;
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[design/sfdd_back.sv]
module sfdd_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_avail,
    input  sfdd_pkg::t_frame_rec        i_rec,
    input  logic [3:0]                  i_keep_mask,
    input  logic                        i_stall,
    output logic                        o_pop,
    output logic                        o_valid,
    output logic [1:0]                  o_frame_status,
    output logic signed [sfdd_pkg::VAL_W-1:0] o_value_a,
    output logic signed [sfdd_pkg::VAL_W-1:0] o_value_b,
    output logic signed [sfdd_pkg::VAL_W-1:0] o_value_c,
    output logic signed [sfdd_pkg::VAL_W-1:0] o_value_d,
    output logic [3:0]                  o_pedal_nibble,
    output logic [3:0]                  o_link_mask,
    output logic [1:0]                  o_direction,
    output logic                        o_wheel0_event,
    output logic                        o_wheel1_event,
    output logic [sfdd_pkg::TIME_W-1:0] o_wheel_time
);

    localparam int VW = sfdd_pkg::VAL_W;

    logic                 r_valid;
    logic [3:0]           r_wheel0;
    logic [3:0]           r_wheel1;
    logic [1:0]           r_status;
    logic signed [VW-1:0] r_val [4];
    logic [3:0]           r_pedal;
    logic [3:0]           r_link;
    logic [1:0]           r_dir;
    logic                 r_ev0;
    logic                 r_ev1;
    logic [sfdd_pkg::TIME_W-1:0] r_time;

    logic [7:0]           bb [sfdd_pkg::DATA_BYTES];
    logic                 dir_bad;
    logic                 dir_on;
    logic                 ev0;
    logic                 ev1;
    logic [1:0]           n_status;
    logic signed [VW-1:0] n_val [4];
    logic [3:0]           n_pedal;
    logic [3:0]           n_link;
    logic [1:0]           n_dir;
    logic                 n_ev0;
    logic                 n_ev1;
    logic [sfdd_pkg::TIME_W-1:0] n_time;
    logic signed [VW-1:0] chan_raw [4];

    // Output register frees when empty or being taken
    assign o_pop = i_avail && (!r_valid || !i_stall);

    always_comb begin
        for (int k = 0; k < sfdd_pkg::DATA_BYTES; k++) begin
            bb[k] = i_rec.body[8*k +: 8];
        end
        for (int c = 0; c < 4; c++) begin
            chan_raw[c] = VW'(signed'({bb[2*c+1], bb[2*c]}));
        end
    end

    assign dir_bad = (bb[3] > sfdd_pkg::DIR_MAX);
    assign dir_on  = (bb[3] != 8'h00);
    assign ev0     = dir_on && (bb[7][3:0] != r_wheel0);
    assign ev1     = dir_on && (bb[7][7:4] != r_wheel1);

    // Decode one frame record
    always_comb begin
        n_status = sfdd_pkg::FS_STATUS_OK;
        for (int c = 0; c < 4; c++) n_val[c] = '0;
        n_pedal = '0;
        n_link  = '0;
        n_dir   = '0;
        n_ev0   = 1'b0;
        n_ev1   = 1'b0;
        n_time  = '0;
        if (i_rec.err) begin
            n_status = sfdd_pkg::FS_CHECK_ERR;
        end else if (i_rec.is_chan) begin
            n_status = sfdd_pkg::FS_CHANNEL_OK;
            for (int c = 0; c < 4; c++) begin
                n_val[c] = i_keep_mask[c] ? chan_raw[c] : -chan_raw[c];
            end
        end else if (dir_bad) begin
            n_status = sfdd_pkg::FS_DIR_ERR;
        end else begin
            n_val[0] = VW'(signed'(bb[1]));
            n_val[1] = VW'(signed'(bb[2]));
            n_pedal  = bb[0][7:4] ^ sfdd_pkg::PEDAL_XOR;
            n_link   = ~bb[0][3:0];
            n_dir    = bb[3][1:0];
            n_ev0    = ev0;
            n_ev1    = ev1;
            n_time   = (ev0 || ev1) ? {bb[6][3:0], bb[5], bb[4]} : '0;
        end
    end

    // Result register and stored wheel nibbles
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_wheel0 <= '0;
            r_wheel1 <= '0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
            if (!i_rec.err && !i_rec.is_chan && !dir_bad) begin
                r_wheel0 <= bb[7][3:0];
                r_wheel1 <= bb[7][7:4];
            end
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_status <= n_status;
            r_val    <= n_val;
            r_pedal  <= n_pedal;
            r_link   <= n_link;
            r_dir    <= n_dir;
            r_ev0    <= n_ev0;
            r_ev1    <= n_ev1;
            r_time   <= n_time;
        end
    end

    assign o_valid        = r_valid;
    assign o_frame_status = r_status;
    assign o_value_a      = r_val[0];
    assign o_value_b      = r_val[1];
    assign o_value_c      = r_val[2];
    assign o_value_d      = r_val[3];
    assign o_pedal_nibble = r_pedal;
    assign o_link_mask    = r_link;
    assign o_direction    = r_dir;
    assign o_wheel0_event = r_ev0;
    assign o_wheel1_event = r_ev1;
    assign o_wheel_time   = r_time;

endmodule

[design/sensor_frame_deframer_decoder.sv]
// Channel    | Direction | Handshake          | Payload
// rx bytes   | in        | i_valid / o_stall  | i_rx_byte
// results    | out       | o_valid / i_stall  | o_frame_status .. o_wheel_time
// config     | in        | i_cfg_we           | i_cfg_index, i_cfg_data
//
// One byte is taken every clock while i_valid is high and o_stall is low; the parser
// updates its state in the same cycle. A frame's result passes through the two-frame
// queue between parser and decoder, then the output register, before it is offered.
// o_stall rises only while that queue holds two frames waiting on i_stall.
// Reset is synchronous, active low; it leaves the parser hunting for 0x22.
module sensor_frame_deframer_decoder (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [7:0]                  i_rx_byte,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [1:0]                  o_frame_status,
    output logic signed [sfdd_pkg::VAL_W-1:0] o_value_a,
    output logic signed [sfdd_pkg::VAL_W-1:0] o_value_b,
    output logic signed [sfdd_pkg::VAL_W-1:0] o_value_c,
    output logic signed [sfdd_pkg::VAL_W-1:0] o_value_d,
    output logic [3:0]                  o_pedal_nibble,
    output logic [3:0]                  o_link_mask,
    output logic [1:0]                  o_direction,
    output logic                        o_wheel0_event,
    output logic                        o_wheel1_event,
    output logic [sfdd_pkg::TIME_W-1:0] o_wheel_time,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [7:0]                  i_cfg_data
);

    logic [3:0]           r_keep_mask;
    logic [7:0]           r_limit;

    logic                 accept;
    logic                 push;
    logic                 pop;
    logic                 q_full;
    logic                 q_avail;
    sfdd_pkg::t_frame_rec front_rec;
    sfdd_pkg::t_frame_rec q_rec;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep_mask <= sfdd_pkg::KEEP_RESET;
            r_limit     <= sfdd_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sfdd_pkg::CFG_KEEP_MASK: r_keep_mask <= i_cfg_data[3:0];
                sfdd_pkg::CFG_LIMIT:     r_limit     <= i_cfg_data;
                default:                 r_limit     <= r_limit;
            endcase
        end
    end

    assign o_stall = q_full;
    assign accept  = i_valid && !o_stall;

    sfdd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_rx_byte (i_rx_byte),
        .i_limit   (r_limit),
        .o_push    (push),
        .o_rec     (front_rec)
    );

    sfdd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (front_rec),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_avail (q_avail),
        .o_rec   (q_rec)
    );

    sfdd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_avail        (q_avail),
        .i_rec          (q_rec),
        .i_keep_mask    (r_keep_mask),
        .i_stall        (i_stall),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .o_frame_status (o_frame_status),
        .o_value_a      (o_value_a),
        .o_value_b      (o_value_b),
        .o_value_c      (o_value_c),
        .o_value_d      (o_value_d),
        .o_pedal_nibble (o_pedal_nibble),
        .o_link_mask    (o_link_mask),
        .o_direction    (o_direction),
        .o_wheel0_event (o_wheel0_event),
        .o_wheel1_event (o_wheel1_event),
        .o_wheel_time   (o_wheel_time)
    );

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    // Parser position, mirrored from the byte stream
    typedef enum logic [1:0] {PM_HUNT, PM_HEADER, PM_BODY} t_parse_mode;

    // One decoded frame as seen on the result channel
    typedef struct packed {
        logic [1:0]                        status;
        logic signed [sfdd_pkg::VAL_W-1:0] value_a;
        logic signed [sfdd_pkg::VAL_W-1:0] value_b;
        logic signed [sfdd_pkg::VAL_W-1:0] value_c;
        logic signed [sfdd_pkg::VAL_W-1:0] value_d;
        logic [3:0]                        pedal;
        logic [3:0]                        link;
        logic [1:0]                        direction;
        logic                              wheel0;
        logic                              wheel1;
        logic [sfdd_pkg::TIME_W-1:0]       wheel_time;
    } t_frame_result;

    // Frame tracker: follows the byte stream, decodes frames, checks results
    class t_frame_tracker;
        logic [3:0]    keep_mask  = sfdd_pkg::KEEP_RESET;
        logic [7:0]    hunt_limit = sfdd_pkg::LIMIT_RESET;
        t_parse_mode   mode       = PM_HUNT;
        logic          is_chan    = 1'b0;
        int unsigned   body_idx   = 0;
        logic [7:0]    running    = sfdd_pkg::CHECK_SEED;
        logic [7:0]    hunt_cnt   = 8'd0;
        logic [7:0]    body [sfdd_pkg::DATA_BYTES];
        logic [3:0]    wheel [2]  = '{4'h0, 4'h0};
        t_frame_result decoded_frames [$];
        int unsigned   failures   = 0;

        function void set_register(logic idx, logic [7:0] val);
            if (idx == sfdd_pkg::CFG_KEEP_MASK) keep_mask = val[3:0];
            else hunt_limit = val;
        endfunction

        function int unsigned pending();
            return decoded_frames.size();
        endfunction

        function void flag(string msg);
            failures++;
            if (failures <= 10) $display("%t mismatch: %s", $realtime, msg);
        endfunction

        function t_frame_result decode_channels();
            t_frame_result r;
            logic signed [sfdd_pkg::VAL_W-1:0] v [4];
            logic [15:0] raw;
            int i;
            r = '0;
            r.status = sfdd_pkg::FS_CHANNEL_OK;
            for (i = 0; i < 4; i++) begin
                raw  = {body[2*i+1], body[2*i]};
                v[i] = {raw[15], raw};
                // clear keep bit flips the sign; -32768 becomes +32768
                if (!keep_mask[i]) v[i] = -v[i];
            end
            r.value_a = v[0];
            r.value_b = v[1];
            r.value_c = v[2];
            r.value_d = v[3];
            return r;
        endfunction

        function t_frame_result decode_status();
            t_frame_result r;
            logic [3:0] n0, n1;
            r  = '0;
            n0 = body[7][3:0];
            n1 = body[7][7:4];
            // bad direction: error only, wheel history untouched
            if (body[3] > sfdd_pkg::DIR_MAX) begin
                r.status = sfdd_pkg::FS_DIR_ERR;
                return r;
            end
            r.status    = sfdd_pkg::FS_STATUS_OK;
            r.value_a   = {{(sfdd_pkg::VAL_W-8){body[1][7]}}, body[1]};
            r.value_b   = {{(sfdd_pkg::VAL_W-8){body[2][7]}}, body[2]};
            r.pedal     = body[0][7:4] ^ sfdd_pkg::PEDAL_XOR;
            r.link      = ~body[0][3:0];
            r.direction = body[3][1:0];
            r.wheel0    = (body[3] != 8'd0) && (n0 != wheel[0]);
            r.wheel1    = (body[3] != 8'd0) && (n1 != wheel[1]);
            if (r.wheel0 || r.wheel1) r.wheel_time = {body[6][3:0], body[5], body[4]};
            // nibbles are stored on every good status frame
            wheel[0] = n0;
            wheel[1] = n1;
            return r;
        endfunction

        // Advance the parser by one accepted byte; queue a frame when one ends
        function void take_byte(logic [7:0] b);
            t_frame_result r;
            case (mode)
                PM_HUNT: begin
                    if (b == sfdd_pkg::END_MARKER || hunt_cnt >= hunt_limit) begin
                        mode     = PM_HEADER;
                        hunt_cnt = 8'd0;
                    end else begin
                        hunt_cnt++;
                    end
                end
                PM_HEADER: begin
                    if (b == sfdd_pkg::HDR_STATUS || b == sfdd_pkg::HDR_CHANNEL) begin
                        is_chan  = (b == sfdd_pkg::HDR_CHANNEL);
                        mode     = PM_BODY;
                        body_idx = 0;
                        running  = sfdd_pkg::CHECK_SEED;
                    end else begin
                        mode     = PM_HUNT;
                        hunt_cnt = 8'd0;
                    end
                end
                default: begin
                    if (body_idx < sfdd_pkg::DATA_BYTES) begin
                        body[body_idx] = b;
                        running ^= b;
                        body_idx++;
                    end else if (body_idx < sfdd_pkg::FRAME_BODY_BYTES - 1) begin
                        running ^= b;
                        body_idx++;
                    end else begin
                        body_idx = 0;
                        r = '0;
                        if (running != 8'd0 || b != sfdd_pkg::END_MARKER) begin
                            r.status = sfdd_pkg::FS_CHECK_ERR;
                            mode     = PM_HUNT;
                            hunt_cnt = 8'd0;
                        end else if (is_chan) begin
                            r    = decode_channels();
                            mode = PM_HEADER;
                        end else begin
                            r = decode_status();
                            if (r.status == sfdd_pkg::FS_DIR_ERR) begin
                                mode     = PM_HUNT;
                                hunt_cnt = 8'd0;
                            end else begin
                                mode = PM_HEADER;
                            end
                        end
                        decoded_frames.push_back(r);
                    end
                end
            endcase
        endfunction

        function void compare(string field, logic signed [31:0] want,
                              logic signed [31:0] got);
            if (want !== got) flag($sformatf("%s expected %0d got %0d", field, want, got));
        endfunction

        function void check_frame(t_frame_result got);
            t_frame_result want;
            if (decoded_frames.size() == 0) begin
                flag($sformatf("result with nothing pending, status %0d", got.status));
                return;
            end
            want = decoded_frames.pop_front();
            compare("frame_status", want.status, got.status);
            compare("value_a", want.value_a, got.value_a);
            compare("value_b", want.value_b, got.value_b);
            compare("value_c", want.value_c, got.value_c);
            compare("value_d", want.value_d, got.value_d);
            compare("pedal_nibble", want.pedal, got.pedal);
            compare("link_mask", want.link, got.link);
            compare("direction", want.direction, got.direction);
            compare("wheel0_event", want.wheel0, got.wheel0);
            compare("wheel1_event", want.wheel1, got.wheel1);
            compare("wheel_time", want.wheel_time, got.wheel_time);
        endfunction

        function void flag_leftovers();
            if (decoded_frames.size() != 0)
                flag($sformatf("%0d frame results never arrived", decoded_frames.size()));
        endfunction
    endclass

    localparam int NUM_PHASES    = 7;
    localparam int PHASE_BYTES   = 150;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_GUARD   = 5000;

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_valid     = 1'b0;
    logic [7:0]              i_rx_byte   = 8'd0;
    logic                    i_stall     = 1'b0;
    logic                    i_cfg_we    = 1'b0;
    logic                    i_cfg_index = 1'b0;
    logic [7:0]              i_cfg_data  = 8'd0;
    logic                    o_stall;
    logic                    o_valid;
    logic [1:0]              o_frame_status;
    logic signed [sfdd_pkg::VAL_W-1:0] o_value_a, o_value_b, o_value_c, o_value_d;
    logic [3:0]              o_pedal_nibble, o_link_mask;
    logic [1:0]              o_direction;
    logic                    o_wheel0_event, o_wheel1_event;
    logic [sfdd_pkg::TIME_W-1:0] o_wheel_time;

    t_frame_tracker sb = new();

    logic [15:0] extremes [4] = '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000};
    int unsigned bytes_sent    = 0;
    int unsigned burst_left    = 0;
    int unsigned hold_requests = 0;
    int unsigned hold_seen     = 0;
    int unsigned hold_left     = 0;
    logic [15:0] stall_pat     = 16'h0;
    logic [3:0]  pat_pos       = 4'd0;

    sensor_frame_deframer_decoder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_frame_status (o_frame_status),
        .o_value_a      (o_value_a),
        .o_value_b      (o_value_b),
        .o_value_c      (o_value_c),
        .o_value_d      (o_value_d),
        .o_pedal_nibble (o_pedal_nibble),
        .o_link_mask    (o_link_mask),
        .o_direction    (o_direction),
        .o_wheel0_event (o_wheel0_event),
        .o_wheel1_event (o_wheel1_event),
        .o_wheel_time   (o_wheel_time),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #1_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Receiver: rotating random stall pattern, plus long hold-offs on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = LONG_HOLD;
            i_stall <= 1'b1;
        end else begin
            if (pat_pos == 4'd0) begin
                case ($urandom_range(0, 3))
                    0:       stall_pat = 16'h0;
                    1:       stall_pat = 16'($urandom & $urandom);
                    default: stall_pat = 16'($urandom);
                endcase
            end
            i_stall <= stall_pat[pat_pos];
            pat_pos++;
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        t_frame_result got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.status     = o_frame_status;
            got.value_a    = o_value_a;
            got.value_b    = o_value_b;
            got.value_c    = o_value_c;
            got.value_d    = o_value_d;
            got.pedal      = o_pedal_nibble;
            got.link       = o_link_mask;
            got.direction  = o_direction;
            got.wheel0     = o_wheel0_event;
            got.wheel1     = o_wheel1_event;
            got.wheel_time = o_wheel_time;
            sb.check_frame(got);
        end
    end

    // Offer one byte, in bursts with random gaps; note it once taken
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.take_byte(b);
        bytes_sent++;
        burst_left--;
    endtask

    // Header, 8 data bytes (byte k at bits 8k+7:8k), checksum, terminator
    task automatic send_frame(input logic [7:0] hdr, input logic [63:0] data,
                              input logic [7:0] chk_err, input logic [7:0] term);
        logic [7:0] chk;
        int k;
        chk = sfdd_pkg::CHECK_SEED;
        for (k = 0; k < sfdd_pkg::DATA_BYTES; k++) chk ^= data[8*k +: 8];
        send_byte(hdr);
        for (k = 0; k < sfdd_pkg::DATA_BYTES; k++) send_byte(data[8*k +: 8]);
        send_byte(chk ^ chk_err);
        send_byte(term);
    endtask

    // Get the parser out of hunt, by end marker or by running out the limit
    task automatic resync();
        logic [7:0]  b;
        int unsigned noise;
        bit          by_limit;
        by_limit = (sb.hunt_limit <= 8'd60) ? ($urandom_range(0, 3) == 0)
                                            : ($urandom_range(0, 15) == 0);
        noise = $urandom_range(0, 3);
        while (sb.mode == PM_HUNT) begin
            if (!by_limit && noise == 0) begin
                b = sfdd_pkg::END_MARKER;
            end else begin
                do b = 8'($urandom); while (b == sfdd_pkg::END_MARKER);
                if (noise != 0) noise--;
            end
            send_byte(b);
        end
    endtask

    // One random transaction group: mostly well-formed frames, some broken
    task automatic random_frame();
        logic [63:0] data;
        logic [7:0]  hdr, chk_err, term, b7;
        int unsigned pick;
        int k;
        if (sb.mode == PM_HUNT) resync();
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            do hdr = 8'($urandom);
            while (hdr == sfdd_pkg::HDR_STATUS || hdr == sfdd_pkg::HDR_CHANNEL);
            send_byte(hdr);
            return;
        end
        data    = {$urandom, $urandom};
        chk_err = ($urandom_range(0, 99) < 8) ? 8'($urandom_range(1, 255)) : 8'h00;
        term    = sfdd_pkg::END_MARKER;
        if ($urandom_range(0, 99) < 5) begin
            do term = 8'($urandom); while (term == sfdd_pkg::END_MARKER);
        end
        if (pick < 54) begin
            hdr = sfdd_pkg::HDR_CHANNEL;
            for (k = 0; k < 4; k++)
                if ($urandom_range(0, 3) == 0) data[16*k +: 16] = extremes[$urandom_range(0, 3)];
        end else begin
            hdr = sfdd_pkg::HDR_STATUS;
            data[31:24] = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(3, 255))
                                                      : 8'($urandom_range(0, 2));
            // keep one or both wheel nibbles often, so events stay selective
            case ($urandom_range(0, 3))
                0:       b7 = {sb.wheel[1], sb.wheel[0]};
                1:       b7 = {sb.wheel[1], 4'($urandom)};
                2:       b7 = {4'($urandom), sb.wheel[0]};
                default: b7 = 8'($urandom);
            endcase
            data[63:56] = b7;
        end
        send_frame(hdr, data, chk_err, term);
    endtask

    task automatic cfg_write(input logic idx, input logic [7:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        sb.set_register(idx, val);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stop sending and let every pending frame come out
    task automatic settle();
        int unsigned guard;
        i_valid <= 1'b0;
        burst_left = 0;
        guard = 0;
        while (sb.pending() != 0 && guard < DRAIN_GUARD) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Main sequence
    initial begin
        logic [3:0]  keep_set  [NUM_PHASES];
        logic [7:0]  limit_set [NUM_PHASES];
        int unsigned start;
        int p;
        keep_set  = '{4'h0, 4'hF, 4'h5, 4'hA, 4'h0, 4'h3, 4'hF};
        limit_set = '{8'd0, 8'd255, 8'd1, 8'd50, 8'd0, 8'd2, 8'd0};
        keep_set[4]  = 4'($urandom);
        limit_set[4] = 8'($urandom_range(1, 255));
        limit_set[6] = 8'($urandom_range(1, 255));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: channel extremes, bad direction, unknown header
        send_byte(sfdd_pkg::END_MARKER);
        send_frame(sfdd_pkg::HDR_CHANNEL, 64'h0000_FFFF_7FFF_8000, 8'h00,
                   sfdd_pkg::END_MARKER);
        send_frame(sfdd_pkg::HDR_STATUS, 64'h12FF_FFFF_037F_80A5, 8'h00,
                   sfdd_pkg::END_MARKER);
        send_byte(sfdd_pkg::END_MARKER);
        send_byte(8'h55);

        // Random phases, each under its own register settings
        for (p = 0; p < NUM_PHASES; p++) begin
            settle();
            cfg_write(sfdd_pkg::CFG_KEEP_MASK, {4'h0, keep_set[p]});
            cfg_write(sfdd_pkg::CFG_LIMIT, limit_set[p]);
            if (p == 1 || p == 4) hold_requests++;
            start = bytes_sent;
            while (bytes_sent - start < PHASE_BYTES) random_frame();
        end

        settle();
        sb.flag_leftovers();
        if (sb.failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[sensor_frame_deframer_decoder.f]
design/sfdd_pkg.sv
design/sfdd_front.sv
design/sfdd_fifo.sv
design/sfdd_back.sv
design/sensor_frame_deframer_decoder.sv
tb/tb_top.sv
